// ----- hdl/pfr_pkg.sv -----
// ---------------------------------------------------------------------------
// Pareto front ranking package
// Command and status words shared by the controller and the datapath.
// ---------------------------------------------------------------------------
package pfr_pkg;

  // The six-bit point_index field caps the store at 64 points, so the
  // command fields carry six-bit indexes and seven-bit counts.
  localparam int IDX_W = 6;
  localparam int CNT_W = 7;

  typedef struct packed {
    logic             wr;          // store the arriving point
    logic [IDX_W-1:0] widx;        // store address of the arriving point
    logic             ovf_set;     // arriving point dropped
    logic [IDX_W-1:0] raddr;       // point store read address
    logic             cmp_vld;     // read data is valid for comparison
    logic [IDX_W-1:0] cmp_idx;     // index of the point on the read port
    logic             peel;        // 1: decrement pass, 0: counting pass
    logic [IDX_W-1:0] new_idx;     // index of the point being loaded
    logic             load_pivot;  // capture read data as the pivot point
    logic             freeze;      // latch the next front
    logic             emit;        // load the result register
    logic [IDX_W-1:0] emit_idx;
    logic [IDX_W-1:0] front;
    logic             last_res;
    logic             clr;         // end of run, clear all ranking state
    logic [CNT_W-1:0] n;           // points loaded
  } cmd_t;

  typedef struct packed {
    logic bit_set;   // scanned point belongs to the current front
    logic out_free;  // result register can take a word
  } sts_t;

endpackage

// ----- hdl/pfr_if.sv -----
// ---------------------------------------------------------------------------
// Pareto front ranking channels
// Point input channel and ranking result channel, valid/ready handshake.
// ---------------------------------------------------------------------------
interface pfr_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] first_objective;
  logic signed [31:0] second_objective;
  logic               last_point;

  modport source (output valid, first_objective, second_objective, last_point,
                  input ready);
  modport sink (input valid, first_objective, second_objective, last_point,
                output ready);
endinterface

interface pfr_out_if;
  logic       valid;
  logic       ready;
  logic [5:0] point_index;
  logic [5:0] front_number;
  logic       front_end;
  logic       last_result;
  logic       points_dropped;

  modport source (output valid, point_index, front_number, front_end, last_result,
                  points_dropped, input ready);
  modport sink (input valid, point_index, front_number, front_end, last_result,
                points_dropped, output ready);
endinterface

// ----- hdl/pfr_ram.sv -----
// ---------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module pfr_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/pfr_datapath.sv -----
// ---------------------------------------------------------------------------
// Pareto front ranking datapath
// Point store, pivot compare, dominator counters, front vectors, result word.
// ---------------------------------------------------------------------------
module pfr_datapath #(
  parameter int POINTS    = 64,
  parameter int OBJ_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic signed [31:0] in_first,
  input  logic signed [31:0] in_second,
  input  pfr_pkg::cmd_t      cmd,
  output pfr_pkg::sts_t      sts,
  pfr_out_if.source          out_res
);
  import pfr_pkg::*;

  localparam int IW = $clog2(POINTS);

  logic signed [63:0]          ext_a, ext_b;
  logic [2*OBJ_WIDTH-1:0]      wdata, rdata;
  logic [2*OBJ_WIDTH-1:0]      pivot_r;
  logic signed [OBJ_WIDTH-1:0] pa, pb, ra, rb;
  logic                        p_dom, r_dom;
  logic [IW-1:0]               cnt_r [POINTS];
  logic [POINTS-1:0]           ranked_r, pend_r, avail, emit_oh;
  logic                        ovf_r;
  logic                        ovalid_r;
  logic [5:0]                  oidx_r, ofront_r;
  logic                        oend_r, olast_r, odrop_r;

  // Sign-extend, then keep the low OBJ_WIDTH bits as a signed key.
  assign ext_a = 64'(in_first);
  assign ext_b = 64'(in_second);
  assign wdata = {ext_a[OBJ_WIDTH-1:0], ext_b[OBJ_WIDTH-1:0]};

  pfr_ram #(.WIDTH(2*OBJ_WIDTH), .DEPTH(POINTS)) u_store (
    .clk   (clk),
    .we    (cmd.wr),
    .waddr (cmd.widx[IW-1:0]),
    .wdata (wdata),
    .raddr (cmd.raddr[IW-1:0]),
    .rdata (rdata)
  );

  assign pa = pivot_r[2*OBJ_WIDTH-1:OBJ_WIDTH];
  assign pb = pivot_r[OBJ_WIDTH-1:0];
  assign ra = rdata[2*OBJ_WIDTH-1:OBJ_WIDTH];
  assign rb = rdata[OBJ_WIDTH-1:0];
  assign p_dom = (pa <= ra) && (pb <= rb) && ((pa < ra) || (pb < rb));
  assign r_dom = (ra <= pa) && (rb <= pb) && ((ra < pa) || (rb < pb));

  always_comb begin
    for (int i = 0; i < POINTS; i++) begin
      avail[i] = (i < int'(cmd.n)) && !ranked_r[i] && (cnt_r[i] == '0);
    end
  end

  assign emit_oh = POINTS'(1) << cmd.emit_idx[IW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < POINTS; i++) begin
        cnt_r[i] <= '0;
      end
      ranked_r <= '0;
      pend_r   <= '0;
      ovf_r    <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      if (cmd.wr) begin
        pivot_r <= wdata;
      end
      if (cmd.load_pivot) begin
        pivot_r <= rdata;
      end
      for (int i = 0; i < POINTS; i++) begin
        if (cmd.clr) begin
          cnt_r[i] <= '0;
        end else if (cmd.cmp_vld) begin
          if (cmd.peel) begin
            if (i == int'(cmd.cmp_idx) && p_dom && cnt_r[i] != '0) begin
              cnt_r[i] <= cnt_r[i] - 1'b1;
            end
          end else if ((i == int'(cmd.cmp_idx) && p_dom) ||
                       (i == int'(cmd.new_idx) && r_dom)) begin
            cnt_r[i] <= cnt_r[i] + 1'b1;
          end
        end
      end
      if (cmd.ovf_set) begin
        ovf_r <= 1'b1;
      end
      if (cmd.freeze) begin
        pend_r   <= avail;
        ranked_r <= ranked_r | avail;
      end
      if (cmd.emit) begin
        oidx_r   <= cmd.emit_idx;
        ofront_r <= cmd.front;
        oend_r   <= (pend_r & ~emit_oh) == '0;
        olast_r  <= cmd.last_res;
        odrop_r  <= ovf_r;
        ovalid_r <= 1'b1;
      end else if (out_res.ready) begin
        ovalid_r <= 1'b0;
      end
      if (cmd.clr) begin
        ranked_r <= '0;
        pend_r   <= '0;
        ovf_r    <= 1'b0;
      end else if (cmd.emit) begin
        pend_r <= pend_r & ~emit_oh;
      end
    end
  end

  assign sts.bit_set  = pend_r[cmd.raddr[IW-1:0]];
  assign sts.out_free = !ovalid_r || out_res.ready;

  assign out_res.valid          = ovalid_r;
  assign out_res.point_index    = oidx_r;
  assign out_res.front_number   = ofront_r;
  assign out_res.front_end      = oend_r;
  assign out_res.last_result    = olast_r;
  assign out_res.points_dropped = odrop_r;

endmodule

// ----- hdl/pfr_ctrl.sv -----
// ---------------------------------------------------------------------------
// Pareto front ranking controller
// Sequences loading, compare sweeps, front latching and result scanning.
// ---------------------------------------------------------------------------
module pfr_ctrl #(
  parameter int POINTS = 64
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_last,
  output logic          in_ready,
  input  pfr_pkg::sts_t sts,
  output pfr_pkg::cmd_t cmd
);
  import pfr_pkg::*;

  localparam int CW = $clog2(POINTS + 1);

  typedef enum logic [2:0] {IDLE, SWEEP, FSTART, SCAN, PIVOT} state_t;

  state_t        state_r, state_nxt;
  logic [CW-1:0] k_r, k_nxt, nidx_r, nidx_nxt, lim_r, lim_nxt, a_r, a_nxt;
  logic [CW-1:0] cidx_r, cidx_nxt, p_r, p_nxt, emit_r, emit_nxt;
  logic [5:0]    front_r, front_nxt;
  logic          cvld_r, cvld_nxt, last_r, last_nxt, peel_r, peel_nxt;
  logic          accept, sweep_done;

  assign in_ready   = (state_r == IDLE);
  assign accept     = in_valid && in_ready;
  assign sweep_done = cvld_r && (cidx_r == lim_r - 1'b1);

  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    nidx_nxt  = nidx_r;
    lim_nxt   = lim_r;
    a_nxt     = a_r;
    cidx_nxt  = cidx_r;
    cvld_nxt  = 1'b0;
    p_nxt     = p_r;
    emit_nxt  = emit_r;
    front_nxt = front_r;
    last_nxt  = last_r;
    peel_nxt  = peel_r;
    cmd       = '0;
    cmd.widx     = IDX_W'(k_r);
    cmd.raddr    = IDX_W'(a_r);
    cmd.cmp_idx  = IDX_W'(cidx_r);
    cmd.new_idx  = IDX_W'(nidx_r);
    cmd.peel     = peel_r;
    cmd.emit_idx = IDX_W'(p_r);
    cmd.front    = front_r;
    cmd.n        = CNT_W'(k_r);
    case (state_r)
      IDLE: begin
        if (accept) begin
          last_nxt = in_last;
          if (k_r < CW'(POINTS)) begin
            cmd.wr   = 1'b1;
            nidx_nxt = k_r;
            k_nxt    = k_r + 1'b1;
            if (k_r != '0) begin
              lim_nxt   = k_r;
              a_nxt     = '0;
              peel_nxt  = 1'b0;
              state_nxt = SWEEP;
            end else if (in_last) begin
              state_nxt = FSTART;
            end
          end else begin
            cmd.ovf_set = 1'b1;
            if (in_last) begin
              state_nxt = FSTART;
            end
          end
        end
      end
      SWEEP: begin
        cmd.cmp_vld = cvld_r;
        if (a_r < lim_r) begin
          cvld_nxt = 1'b1;
          cidx_nxt = a_r;
          a_nxt    = a_r + 1'b1;
        end
        if (sweep_done) begin
          cvld_nxt = 1'b0;
          if (peel_r) begin
            p_nxt     = p_r + 1'b1;
            state_nxt = SCAN;
          end else if (last_r) begin
            state_nxt = FSTART;
          end else begin
            state_nxt = IDLE;
          end
        end
      end
      FSTART: begin
        cmd.freeze = 1'b1;
        p_nxt      = '0;
        state_nxt  = SCAN;
      end
      SCAN: begin
        cmd.raddr = IDX_W'(p_r);
        if (p_r == k_r) begin
          front_nxt = front_r + 1'b1;
          state_nxt = FSTART;
        end else if (!sts.bit_set) begin
          p_nxt = p_r + 1'b1;
        end else if (sts.out_free) begin
          cmd.emit = 1'b1;
          emit_nxt = emit_r + 1'b1;
          if (emit_r + 1'b1 == k_r) begin
            cmd.last_res = 1'b1;
            cmd.clr      = 1'b1;
            k_nxt        = '0;
            emit_nxt     = '0;
            front_nxt    = '0;
            state_nxt    = IDLE;
          end else begin
            state_nxt = PIVOT;
          end
        end
      end
      PIVOT: begin
        cmd.load_pivot = 1'b1;
        a_nxt          = '0;
        lim_nxt        = k_r;
        peel_nxt       = 1'b1;
        state_nxt      = SWEEP;
      end
      default: begin
        state_nxt = IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= IDLE;
      k_r     <= '0;
      nidx_r  <= '0;
      lim_r   <= '0;
      a_r     <= '0;
      cidx_r  <= '0;
      cvld_r  <= 1'b0;
      p_r     <= '0;
      emit_r  <= '0;
      front_r <= '0;
      last_r  <= 1'b0;
      peel_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      nidx_r  <= nidx_nxt;
      lim_r   <= lim_nxt;
      a_r     <= a_nxt;
      cidx_r  <= cidx_nxt;
      cvld_r  <= cvld_nxt;
      p_r     <= p_nxt;
      emit_r  <= emit_nxt;
      front_r <= front_nxt;
      last_r  <= last_nxt;
      peel_r  <= peel_nxt;
    end
  end

endmodule

// ----- hdl/pareto_front_ranking.sv -----
// ---------------------------------------------------------------------------
// Pareto front ranking
// Non-dominated sort of two-objective points into ranked fronts.
// ---------------------------------------------------------------------------
// Load a population one point per word; the word flagged last_point starts
// ranking. Each new point is compared with every stored point through the
// single read port of the point store, one point a cycle, and a comparison
// increments the dominator counter of whichever of the two points is
// dominated. Ranking then latches each front (undominated, not yet ranked
// points), scans indices 0 to N-1 one a cycle, pausing while a member waits
// for the output register or its sweep runs, and for every member sends
// one result word and sweeps the store once more to release the points it
// dominates. Words come front by front, ascending index within a front. Points
// past POINTS are dropped and flagged in points_dropped. No new point is taken
// until the last result word is loaded into the output register.
// ---------------------------------------------------------------------------
module pareto_front_ranking #(
  parameter int POINTS    = 64,
  parameter int OBJ_WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  pfr_in_if.sink    in_pt,
  pfr_out_if.source out_res
);
  import pfr_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequence load sweeps, front latching and result scans.
  pfr_ctrl #(.POINTS(POINTS)) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_pt.valid),
    .in_last  (in_pt.last_point),
    .in_ready (in_pt.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Hold points, counters and the result word.
  pfr_datapath #(.POINTS(POINTS), .OBJ_WIDTH(OBJ_WIDTH)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_first  (in_pt.first_objective),
    .in_second (in_pt.second_objective),
    .cmd       (cmd),
    .sts       (sts),
    .out_res   (out_res)
  );

`ifndef SYNTHESIS
  // The final word of a run always closes its front.
  a_last_closes_front: assert property (@(posedge clk) disable iff (!rst_n)
    out_res.valid && out_res.last_result |-> out_res.front_end)
    else $error("last result without front end");

  // A word that does not close its front is followed by one of the same front.
  a_front_kept: assert property (@(posedge clk) disable iff (!rst_n)
    out_res.valid && out_res.ready && !out_res.front_end |=>
    !out_res.valid || out_res.front_number == $past(out_res.front_number))
    else $error("front number changed inside a front");

  // Reported indices stay within the store.
  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_res.valid |-> int'(out_res.point_index) < POINTS)
    else $error("point index beyond capacity");
`endif

endmodule
